### hw/rtl/cbor_enc_pkg.sv
// Shared types, constants and CBOR head helpers for the log record encoder.
package cbor_enc_pkg;

  localparam int TEXT_LEN_BITS = 16;
  localparam int SizeW = TEXT_LEN_BITS + 2;
  localparam int CapW = 24;
  localparam int CmpW = (SizeW > CapW) ? SizeW : CapW;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  typedef logic [TEXT_LEN_BITS-1:0] len_t;
  typedef logic [SizeW-1:0] size_t;

  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_TEXT = 1'b1;

  localparam logic [2:0] MAJ_UINT = 3'd0;
  localparam logic [2:0] MAJ_TEXT = 3'd3;
  localparam logic [2:0] MAJ_MAP = 3'd5;
  localparam logic [4:0] MAP_PAIRS = 5'd4;
  localparam logic [4:0] AI_U8 = 5'd24;
  localparam logic [4:0] AI_U16 = 5'd25;
  localparam logic [4:0] AI_U32 = 5'd26;
  localparam logic [7:0] KEY_HEAD = 8'h62;
  localparam logic [4:0] FIXED_BYTES = 5'd13;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TAG,
    PH_MSG
  } phase_t;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_TEXT,
    CMD_OVF
  } cmd_kind_t;

  typedef enum logic [3:0] {
    SEG_START,
    SEG_MAP,
    SEG_KEY_TS,
    SEG_HEAD_TS,
    SEG_KEY_LV,
    SEG_HEAD_LV,
    SEG_KEY_TG,
    SEG_HEAD_TG,
    SEG_KEY_MS,
    SEG_HEAD_MS,
    SEG_TEXT,
    SEG_OVF,
    SEG_DONE
  } seg_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] timestamp;
    logic [7:0]  severity;
    len_t        tag_len;
    len_t        msg_len;
    logic [7:0]  text_byte;
    logic        msg_start;
    logic        ends;
    size_t       size;
  } cmd_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } q_stat_t;

  function automatic logic [2:0] head_len(logic [31:0] v);
    logic [2:0] n;
    if (v < 32'd24) n = 3'd1;
    else if (v <= 32'h0000_00ff) n = 3'd2;
    else if (v <= 32'h0000_ffff) n = 3'd3;
    else n = 3'd5;
    return n;
  endfunction

  // Byte k of the shortest head for value v; the argument follows big-endian.
  function automatic logic [7:0] head_byte(logic [2:0] major, logic [31:0] v, logic [2:0] k);
    logic [2:0] n;
    logic [4:0] ai;
    logic [7:0] b;
    n = head_len(v);
    if (v < 32'd24) ai = v[4:0];
    else if (v <= 32'h0000_00ff) ai = AI_U8;
    else if (v <= 32'h0000_ffff) ai = AI_U16;
    else ai = AI_U32;
    case (k)
      3'd0: b = {major, ai};
      3'd1: b = (n == 3'd2) ? v[7:0] : ((n == 3'd3) ? v[15:8] : v[31:24]);
      3'd2: b = (n == 3'd3) ? v[7:0] : v[23:16];
      3'd3: b = v[15:8];
      3'd4: b = v[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] key_byte(logic [7:0] c0, logic [7:0] c1, logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0: b = KEY_HEAD;
      3'd1: b = c0;
      default: b = c1;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/cbor_enc_front.sv
// Front end: accepts input transactions, tracks record progress and queues encode commands.
module cbor_enc_front
  import cbor_enc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [31:0]       in_timestamp,
  input  logic [7:0]        in_severity,
  input  logic [15:0]       in_tag_length,
  input  logic [15:0]       in_message_length,
  input  logic [7:0]        in_text_byte,
  input  logic [CapW-1:0]   capacity,
  input  q_stat_t           q_stat,
  output logic              push,
  output cmd_t              push_cmd
);

  phase_t phase_r, phase_nxt;
  len_t   bytes_left_r, bytes_left_nxt;
  len_t   saved_ml_r, saved_ml_nxt;
  logic   dropping_r, dropping_nxt;
  size_t  saved_size_r, saved_size_nxt;

  logic   accept;
  len_t   tl, ml, left_dec;
  logic [4:0] head_sum;
  size_t  size;
  logic   overflow;

  assign in_ready = !q_stat.full;
  assign accept = in_valid && !q_stat.full;

  assign tl = len_t'(in_tag_length);
  assign ml = len_t'(in_message_length);
  assign head_sum = FIXED_BYTES + 5'(head_len(in_timestamp))
                  + 5'(head_len(32'(in_severity))) + 5'(head_len(32'(tl)))
                  + 5'(head_len(32'(ml)));
  assign size = SizeW'(tl) + SizeW'(ml) + SizeW'(head_sum);
  assign overflow = CmpW'(size) > CmpW'(capacity);
  assign left_dec = bytes_left_r - len_t'(1);

  always_comb begin
    phase_nxt = phase_r;
    bytes_left_nxt = bytes_left_r;
    saved_ml_nxt = saved_ml_r;
    dropping_nxt = dropping_r;
    saved_size_nxt = saved_size_r;
    push = 1'b0;
    push_cmd.kind = CMD_TEXT;
    push_cmd.timestamp = in_timestamp;
    push_cmd.severity = in_severity;
    push_cmd.tag_len = tl;
    push_cmd.msg_len = saved_ml_r;
    push_cmd.text_byte = in_text_byte;
    push_cmd.msg_start = 1'b0;
    push_cmd.ends = 1'b0;
    push_cmd.size = saved_size_r;
    if (accept) begin
      if (in_req_type == REQ_HEADER) begin
        saved_size_nxt = size;
        saved_ml_nxt = ml;
        dropping_nxt = overflow;
        if (tl != '0) begin
          phase_nxt = PH_TAG;
          bytes_left_nxt = tl;
        end else if (ml != '0) begin
          phase_nxt = PH_MSG;
          bytes_left_nxt = ml;
        end else begin
          phase_nxt = PH_IDLE;
          bytes_left_nxt = '0;
        end
        push = 1'b1;
        push_cmd.kind = overflow ? CMD_OVF : CMD_HDR;
        push_cmd.msg_len = ml;
        push_cmd.size = size;
        push_cmd.msg_start = (tl == '0);
        push_cmd.ends = overflow || ((tl == '0) && (ml == '0));
      end else if ((phase_r != PH_IDLE) && (bytes_left_r != '0)) begin
        bytes_left_nxt = left_dec;
        push = !dropping_r;
        if (left_dec == '0) begin
          if (phase_r == PH_TAG) begin
            // The tag is complete: the message key and head follow this byte.
            push_cmd.msg_start = 1'b1;
            if (saved_ml_r != '0) begin
              phase_nxt = PH_MSG;
              bytes_left_nxt = saved_ml_r;
            end else begin
              phase_nxt = PH_IDLE;
              push_cmd.ends = 1'b1;
            end
          end else begin
            phase_nxt = PH_IDLE;
            push_cmd.ends = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bytes_left_r <= '0;
      saved_ml_r <= '0;
      dropping_r <= 1'b0;
      saved_size_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      saved_ml_r <= saved_ml_nxt;
      dropping_r <= dropping_nxt;
      saved_size_r <= saved_size_nxt;
    end
  end

endmodule

### hw/rtl/cbor_enc_queue.sv
// Short command queue between the front end and the byte sequencer.
module cbor_enc_queue
  import cbor_enc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head_cmd,
  output q_stat_t q_stat
);

  cmd_t             entries_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_stat.full = (count_r == QCntW'(QDepth));
  assign q_stat.empty = (count_r == '0);
  assign q_stat.count = count_r;
  assign head_cmd = entries_r[rd_ptr_r];

  assign do_push = push && !q_stat.full;
  assign do_pop = pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPtrW'(1) : rd_ptr_r;
    count_nxt = count_r + QCntW'(do_push) - QCntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### hw/rtl/cbor_enc_back.sv
// Back end: expands queued commands into CBOR bytes, one per cycle unless stalled, into an output register.
module cbor_enc_back
  import cbor_enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        head_cmd,
  input  q_stat_t     q_stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_end,
  output logic        out_status,
  output size_t       out_size
);

  seg_t       seg_r, seg_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_end_r;
  logic       out_status_r;
  size_t      out_size_r;

  seg_t       seg;
  seg_t       next_seg;
  logic [2:0] seg_len;
  logic [7:0] cur_byte;
  logic       last_in_seg;
  logic       step;

  assign step = !q_stat.empty && (!out_valid_r || out_ready);

  // A fresh command starts in the segment that its kind selects.
  always_comb begin
    seg = seg_r;
    if (seg_r == SEG_START) begin
      unique case (head_cmd.kind)
        CMD_HDR:  seg = SEG_MAP;
        CMD_TEXT: seg = SEG_TEXT;
        CMD_OVF:  seg = SEG_OVF;
        default:  seg = SEG_OVF;
      endcase
    end
  end

  always_comb begin
    seg_len = 3'd1;
    cur_byte = 8'h00;
    next_seg = SEG_DONE;
    unique case (seg)
      SEG_MAP: begin
        cur_byte = {MAJ_MAP, MAP_PAIRS};
        next_seg = SEG_KEY_TS;
      end
      SEG_KEY_TS: begin
        seg_len = 3'd3;
        cur_byte = key_byte("t", "s", idx_r);
        next_seg = SEG_HEAD_TS;
      end
      SEG_HEAD_TS: begin
        seg_len = head_len(head_cmd.timestamp);
        cur_byte = head_byte(MAJ_UINT, head_cmd.timestamp, idx_r);
        next_seg = SEG_KEY_LV;
      end
      SEG_KEY_LV: begin
        seg_len = 3'd3;
        cur_byte = key_byte("l", "v", idx_r);
        next_seg = SEG_HEAD_LV;
      end
      SEG_HEAD_LV: begin
        seg_len = head_len(32'(head_cmd.severity));
        cur_byte = head_byte(MAJ_UINT, 32'(head_cmd.severity), idx_r);
        next_seg = SEG_KEY_TG;
      end
      SEG_KEY_TG: begin
        seg_len = 3'd3;
        cur_byte = key_byte("t", "g", idx_r);
        next_seg = SEG_HEAD_TG;
      end
      SEG_HEAD_TG: begin
        seg_len = head_len(32'(head_cmd.tag_len));
        cur_byte = head_byte(MAJ_TEXT, 32'(head_cmd.tag_len), idx_r);
        next_seg = head_cmd.msg_start ? SEG_KEY_MS : SEG_DONE;
      end
      SEG_KEY_MS: begin
        seg_len = 3'd3;
        cur_byte = key_byte("m", "s", idx_r);
        next_seg = SEG_HEAD_MS;
      end
      SEG_HEAD_MS: begin
        seg_len = head_len(32'(head_cmd.msg_len));
        cur_byte = head_byte(MAJ_TEXT, 32'(head_cmd.msg_len), idx_r);
        next_seg = SEG_DONE;
      end
      SEG_TEXT: begin
        cur_byte = head_cmd.text_byte;
        next_seg = head_cmd.msg_start ? SEG_KEY_MS : SEG_DONE;
      end
      default: begin
        cur_byte = 8'h00;
        next_seg = SEG_DONE;
      end
    endcase
  end

  assign last_in_seg = (idx_r == seg_len - 3'd1);
  assign pop = step && last_in_seg && (next_seg == SEG_DONE);

  always_comb begin
    seg_nxt = seg_r;
    idx_nxt = idx_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
      if (!last_in_seg) begin
        seg_nxt = seg;
        idx_nxt = idx_r + 3'd1;
      end else if (next_seg == SEG_DONE) begin
        seg_nxt = SEG_START;
        idx_nxt = 3'd0;
      end else begin
        seg_nxt = next_seg;
        idx_nxt = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SEG_START;
      idx_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      seg_r <= seg_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte_r <= cur_byte;
      out_end_r <= head_cmd.ends && last_in_seg && (next_seg == SEG_DONE);
      out_status_r <= (head_cmd.kind == CMD_OVF);
      out_size_r <= head_cmd.size;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte = out_byte_r;
  assign out_end = out_end_r;
  assign out_status = out_status_r;
  assign out_size = out_size_r;

endmodule

### hw/rtl/cbor_log_record_encoder.sv
// Top level of the CBOR log record encoder: capacity register, front end, queue and byte sequencer.
//
//   Channel   Direction  Handshake            Payload
//   in_*      slave      tvalid/tready        tdata: header fields or text byte, tuser: kind
//   out_*     master     tvalid/tready/tlast  tdata: byte and record size, tuser: overflow
//   cfg_*     APB slave  psel/penable/pready  capacity at byte address 0
//
// The input side takes one transaction per cycle while the four-entry command queue has room.
// The output side gives one byte per cycle while a command is queued and out_tready allows; a header
// becomes the map head and the keys and heads, or a single zero byte where the record overflows, and
// a text byte becomes itself, followed by the message key and head where it closes the tag.
// The first byte of an item is held in the command queue before it is loaded into the output register.
// Reset is synchronous; capacity comes out of reset at 256 and no clearing pass is needed.
// Either side may stall: the queue and the output register hold everything in flight.
module cbor_log_record_encoder
  import cbor_enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] timestamp, [39:32] severity, [55:40] tag_length, [71:56] message_length,
  // [79:72] text_byte
  input  logic [79:0] in_tdata,
  // [0] req_type
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_byte, [25:8] record_size, [31:26] zero
  output logic [31:0] out_tdata,
  // [0] status
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [CapW-1:0] capacity_r, capacity_nxt;
  logic            cfg_write;

  q_stat_t    q_stat;
  logic       push, pop;
  cmd_t       push_cmd, head_cmd;
  logic [7:0] out_byte;
  size_t      out_size;

  assign cfg_pready = 1'b1;
  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign capacity_nxt = (cfg_write && !cfg_paddr[2]) ? cfg_pwdata[CapW-1:0] : capacity_r;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(capacity_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CapW'(256);
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  cbor_enc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_tvalid),
    .in_ready          (in_tready),
    .in_req_type       (in_tuser),
    .in_timestamp      (in_tdata[31:0]),
    .in_severity       (in_tdata[39:32]),
    .in_tag_length     (in_tdata[55:40]),
    .in_message_length (in_tdata[71:56]),
    .in_text_byte      (in_tdata[79:72]),
    .capacity          (capacity_r),
    .q_stat            (q_stat),
    .push              (push),
    .push_cmd          (push_cmd)
  );

  cbor_enc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  cbor_enc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_byte),
    .out_end    (out_tlast),
    .out_status (out_tuser),
    .out_size   (out_size)
  );

  assign out_tdata = {6'd0, 18'(out_size), out_byte};

  // An overflow result is a single zero byte that closes its record.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata[7:0] == 8'h00))
    else $error("overflow result without record end or with a non-zero byte");

  // Nothing can reach the output register without first passing through the queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty && !out_tvalid |=> !out_tvalid)
    else $error("output became valid with an empty command queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCntW'(QDepth))
    else $error("command queue count beyond its depth");

endmodule

### sim/cbor_log_record_encoder_tb.sv
// Self-checking testbench for the CBOR log record encoder: directed table, then random records.
module cbor_log_record_encoder_tb;
  import cbor_enc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS = 25;
  localparam int NUM_PHASES = 6;
  localparam int NUM_ROWS = 25;
  // Map head plus four two-character keys of three bytes each.
  localparam int MAP_AND_KEYS = 13;

  localparam logic [2:0] CAPACITY_ADDR = 3'd0;
  localparam logic [23:0] CAPACITY_RESET = 24'd256;
  localparam logic [15:0] KEY_TS = "ts";
  localparam logic [15:0] KEY_LV = "lv";
  localparam logic [15:0] KEY_TG = "tg";
  localparam logic [15:0] KEY_MS = "ms";

  localparam logic [31:0] TS_EDGES [8] = '{32'd0, 32'd23, 32'd24, 32'd255, 32'd256,
                                           32'd65535, 32'd65536, 32'hFFFF_FFFF};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
    size_t      size;
  } enc_byte_t;

  typedef struct packed {
    logic        req;
    logic [31:0] ts;
    logic [7:0]  sev;
    len_t        tl;
    len_t        ml;
    logic [7:0]  tb;
    logic        typed_ovf;
    size_t       ovf_size;
  } dir_row_t;

  // Overflow rows carry their single result typed in; the rest go through the predictor.
  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'hA5, 1'b0, 18'd0},
    '{REQ_HEADER, 32'd0,         8'd0,   16'd0,      16'd0,      8'h00, 1'b0, 18'd0},
    '{REQ_HEADER, 32'd23,        8'd23,  16'd2,      16'd3,      8'h00, 1'b0, 18'd0},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'h61, 1'b0, 18'd0},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'hFF, 1'b0, 18'd0},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'h00, 1'b0, 18'd0},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'h80, 1'b0, 18'd0},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'h7F, 1'b0, 18'd0},
    '{REQ_HEADER, 32'd24,        8'd24,  16'd0,      16'd2,      8'h00, 1'b0, 18'd0},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'h01, 1'b0, 18'd0},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'hFE, 1'b0, 18'd0},
    '{REQ_HEADER, 32'd255,       8'd255, 16'd3,      16'd0,      8'h00, 1'b0, 18'd0},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'h55, 1'b0, 18'd0},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'hAA, 1'b0, 18'd0},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'h33, 1'b0, 18'd0},
    '{REQ_HEADER, 32'd256,       8'h80,  16'd1,      16'd1,      8'h00, 1'b0, 18'd0},
    '{REQ_HEADER, 32'd65535,     8'd1,   16'd1,      16'd1,      8'h00, 1'b0, 18'd0},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'h74, 1'b0, 18'd0},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'h6D, 1'b0, 18'd0},
    '{REQ_HEADER, 32'hFFFF_FFFF, 8'd0,   16'd0,      16'd0,      8'h00, 1'b0, 18'd0},
    '{REQ_HEADER, 32'hFFFF_FFFF, 8'hFF,  16'hFFFF,   16'hFFFF,   8'h00, 1'b1, 18'd131096},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'h42, 1'b0, 18'd0},
    '{REQ_HEADER, 32'd0,         8'd0,   16'd0,      16'd250,    8'h00, 1'b1, 18'd268},
    '{REQ_TEXT,   32'd0,         8'd0,   16'd0,      16'd0,      8'h43, 1'b0, 18'd0},
    '{REQ_HEADER, 32'd65536,     8'd0,   16'd300,    16'd0,      8'h00, 1'b1, 18'd323}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor state.
  phase_t      rec_phase = PH_IDLE;
  len_t        text_left = '0;
  len_t        msg_len_held = '0;
  logic        discarding = 1'b0;
  size_t       size_held = '0;
  logic [23:0] capacity_shadow = CAPACITY_RESET;

  logic [7:0] enc_buf [$];
  enc_byte_t  expected_bytes [$];

  int mismatches = 0;
  int cycle_count = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int sink_gap = 0;
  bit steady = 1'b0;

  cbor_log_record_encoder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  function automatic int head_size(logic [31:0] v);
    if (v < 32'd24) return 1;
    if (v <= 32'hFF) return 2;
    if (v <= 32'hFFFF) return 3;
    return 5;
  endfunction

  function automatic void buf_head(logic [2:0] major, logic [31:0] v);
    case (head_size(v))
      1: enc_buf.push_back({major, v[4:0]});
      2: begin
        enc_buf.push_back({major, AI_U8});
        enc_buf.push_back(v[7:0]);
      end
      3: begin
        enc_buf.push_back({major, AI_U16});
        enc_buf.push_back(v[15:8]);
        enc_buf.push_back(v[7:0]);
      end
      default: begin
        enc_buf.push_back({major, AI_U32});
        enc_buf.push_back(v[31:24]);
        enc_buf.push_back(v[23:16]);
        enc_buf.push_back(v[15:8]);
        enc_buf.push_back(v[7:0]);
      end
    endcase
  endfunction

  function automatic void buf_key(logic [15:0] chars);
    enc_buf.push_back(KEY_HEAD);
    enc_buf.push_back(chars[15:8]);
    enc_buf.push_back(chars[7:0]);
  endfunction

  function automatic void flush_bytes(logic closes);
    int n;
    n = enc_buf.size();
    for (int i = 0; i < n; i++) begin
      expected_bytes.push_back('{enc_buf[i], closes && (i == n - 1), 1'b0, size_held});
    end
    enc_buf.delete();
  endfunction

  // Works out the encoded bytes that one accepted transaction produces.
  function automatic void predict_item(logic req, logic [31:0] ts, logic [7:0] sev,
                                       len_t tl, len_t ml, logic [7:0] tb);
    int total;
    logic closes;
    enc_buf.delete();
    if (req == REQ_HEADER) begin
      total = MAP_AND_KEYS + head_size(ts) + head_size(sev) + head_size(tl) + tl
            + head_size(ml) + ml;
      size_held = total[SizeW-1:0];
      msg_len_held = ml;
      if (total > capacity_shadow) begin
        discarding = 1'b1;
        if (tl != 0) begin
          rec_phase = PH_TAG;
          text_left = tl;
        end else if (ml != 0) begin
          rec_phase = PH_MSG;
          text_left = ml;
        end else begin
          rec_phase = PH_IDLE;
          text_left = '0;
        end
        expected_bytes.push_back('{8'h00, 1'b1, 1'b1, size_held});
      end else begin
        discarding = 1'b0;
        buf_head(MAJ_MAP, 32'(MAP_PAIRS));
        buf_key(KEY_TS);
        buf_head(MAJ_UINT, ts);
        buf_key(KEY_LV);
        buf_head(MAJ_UINT, 32'(sev));
        buf_key(KEY_TG);
        buf_head(MAJ_TEXT, 32'(tl));
        if (tl != 0) begin
          rec_phase = PH_TAG;
          text_left = tl;
          flush_bytes(1'b0);
        end else begin
          buf_key(KEY_MS);
          buf_head(MAJ_TEXT, 32'(ml));
          text_left = ml;
          rec_phase = (ml != 0) ? PH_MSG : PH_IDLE;
          flush_bytes(ml == 0);
        end
      end
    end else if (rec_phase != PH_IDLE && text_left != 0) begin
      closes = 1'b0;
      enc_buf.push_back(tb);
      text_left = text_left - 1'b1;
      if (rec_phase == PH_TAG) begin
        if (text_left == 0) begin
          buf_key(KEY_MS);
          buf_head(MAJ_TEXT, 32'(msg_len_held));
          if (msg_len_held != 0) begin
            rec_phase = PH_MSG;
            text_left = msg_len_held;
          end else begin
            rec_phase = PH_IDLE;
            closes = 1'b1;
          end
        end
      end else if (text_left == 0) begin
        rec_phase = PH_IDLE;
        closes = 1'b1;
      end
      if (!discarding) flush_bytes(closes);
      else enc_buf.delete();
    end
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic len_t pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return 16'($urandom_range(0, 6));
    if (r == 8) return 16'($urandom_range(7, 40));
    return 16'($urandom);
  endfunction

  task automatic send_item(input logic req, input logic [31:0] ts, input logic [7:0] sev,
                           input len_t tl, input len_t ml, input logic [7:0] tb,
                           input logic typed_ovf, input size_t ovf_size);
    int gap;
    int before_count;
    gap = (!steady && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {tb, ml, tl, sev, ts};
    do @(posedge clk); while (!in_tready);
    before_count = expected_bytes.size();
    predict_item(req, ts, sev, tl, ml, tb);
    if (typed_ovf) begin
      while (expected_bytes.size() > before_count) void'(expected_bytes.pop_back());
      expected_bytes.push_back('{8'h00, 1'b1, 1'b1, ovf_size});
    end
  endtask

  // Stops offering, then waits for every outstanding byte and a little more.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic check_capacity(input logic [23:0] want);
    logic [31:0] rd;
    cfg_access(1'b0, CAPACITY_ADDR, 32'd0, rd);
    if (rd !== {8'd0, want})
      report_mismatch($sformatf("capacity reads %0h, want %0h", rd, want));
  endtask

  task automatic random_record(output int sent);
    logic [31:0] ts;
    logic [7:0] sev;
    len_t tl;
    len_t ml;
    int nbytes;
    case ($urandom_range(0, 4))
      0: ts = $urandom_range(0, 23);
      1: ts = $urandom_range(24, 255);
      2: ts = $urandom_range(256, 65535);
      3: ts = $urandom;
      default: ts = TS_EDGES[$urandom_range(0, 7)];
    endcase
    sev = 8'($urandom);
    tl = pick_len();
    ml = pick_len();
    nbytes = tl + ml;
    // Long texts are cut short and abandoned by the next header; a few records break early.
    if (nbytes > 60) nbytes = $urandom_range(0, 5);
    else if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, nbytes);
    send_item(REQ_HEADER, ts, sev, tl, ml, 8'($urandom), 1'b0, '0);
    repeat (nbytes) begin
      send_item(REQ_TEXT, $urandom, 8'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom), 1'b0, '0);
    end
    sent = nbytes + 1;
    if ($urandom_range(0, 7) == 0) begin
      send_item(REQ_TEXT, $urandom, 8'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom), 1'b0, '0);
    end
  endtask

  // Result side: random back-pressure, plus one long hold whenever the stimulus asks for it.
  initial begin
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
      end else if (sink_gap > 0) begin
        out_tready <= 1'b0;
        sink_gap--;
      end else begin
        out_tready <= 1'b1;
        if (!steady && $urandom_range(0, 7) == 0) sink_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_output
    enc_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h arrived with nothing outstanding", out_tdata[7:0]));
      end else begin
        want = expected_bytes.pop_front();
        if (out_tdata[7:0] !== want.data)
          report_mismatch($sformatf("byte %02h, want %02h", out_tdata[7:0], want.data));
        if (out_tdata[25:8] !== want.size)
          report_mismatch($sformatf("record size %0d, want %0d", out_tdata[25:8], want.size));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("end mark %b, want %b", out_tlast, want.last));
        if (out_tuser !== want.ovf)
          report_mismatch($sformatf("overflow flag %b, want %b", out_tuser, want.ovf));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cbor_log_record_encoder test failed");
      $finish;
    end
  end

  initial begin
    logic [23:0] caps [NUM_PHASES];
    logic [31:0] unused_rd;
    int items;
    int sent;
    int pause_at;
    bit paused;

    caps = '{24'd0, 24'hFF_FFFF, 24'd17, 24'($urandom_range(18, 60)),
             24'($urandom_range(16, 200)), CAPACITY_RESET};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    check_capacity(CAPACITY_RESET);
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_item(DIRECTED[i].req, DIRECTED[i].ts, DIRECTED[i].sev, DIRECTED[i].tl,
                DIRECTED[i].ml, DIRECTED[i].tb, DIRECTED[i].typed_ovf, DIRECTED[i].ovf_size);
    end
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      cfg_access(1'b1, CAPACITY_ADDR, {8'd0, caps[p]}, unused_rd);
      capacity_shadow = caps[p];
      check_capacity(caps[p]);
      steady = (p == 2);
      // The long hold lands while the sender keeps offering, so the input side backs up.
      if (p == 1 || p == 4) hold_requests++;
      items = 0;
      paused = 1'b0;
      pause_at = $urandom_range(10, 20);
      while (items < PHASE_ITEMS) begin
        random_record(sent);
        items += sent;
        if (!paused && items >= pause_at) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("cbor_log_record_encoder test passed");
    end else begin
      $display("cbor_log_record_encoder test failed");
    end
    $finish;
  end

endmodule
